/* design/amgs_pkg.sv */
// Shared types, constants and helpers for the adjacency matrix graph store.
`timescale 1ns / 1ps
package amgs_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int AW    = $clog2(MAX_VERTICES);
   localparam int CW    = $clog2(MAX_VERTICES + 1);
   localparam int CNTW  = $clog2(2 * MAX_VERTICES);
   localparam int MAT_DEPTH = MAX_VERTICES * MAX_VERTICES;
   localparam int MW    = $clog2(MAT_DEPTH);
   localparam int DW    = 32;

   localparam logic [3:0] ACT_ADD_VERTEX = 4'd0;
   localparam logic [3:0] ACT_REM_VERTEX = 4'd1;
   localparam logic [3:0] ACT_ADD_EDGE   = 4'd2;
   localparam logic [3:0] ACT_REM_EDGE   = 4'd3;
   localparam logic [3:0] ACT_ADJACENT   = 4'd4;
   localparam logic [3:0] ACT_NEIGHBORS  = 4'd5;
   localparam logic [3:0] ACT_GET_VVAL   = 4'd6;
   localparam logic [3:0] ACT_SET_VVAL   = 4'd7;
   localparam logic [3:0] ACT_GET_EDGE   = 4'd8;
   localparam logic [3:0] ACT_SET_EDGE   = 4'd9;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_MISSING     = 3'd1;
   localparam logic [2:0] ST_PRESENT     = 3'd2;
   localparam logic [2:0] ST_FULL        = 3'd3;
   localparam logic [2:0] ST_NO_EDGE     = 3'd4;
   localparam logic [2:0] ST_NO_NEIGHBOR = 3'd5;

   typedef struct packed {
      logic [3:0]           action;
      logic signed [DW-1:0] vertex_a;
      logic signed [DW-1:0] vertex_b;
      logic signed [DW-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic signed [DW-1:0] data_word;
      logic signed [DW-1:0] neighbor_id;
      logic                 is_adjacent;
      logic                 last;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_NOP, DP_LOAD, DP_SRCH_A, DP_SRCH_B, DP_CLR, DP_ADD, DP_VRD, DP_VWR,
      DP_ERD, DP_EWR, DP_NBR, DP_NEND, DP_CRD, DP_CWR, DP_RMFIN
   } dp_op_type;

   typedef enum logic [1:0] {
      DS_ZERO, DS_ONES, DS_VALUE, DS_WEIGHT
   } dsel_type;

   typedef struct packed {
      dp_op_type  op;
      logic       emit;
      logic [2:0] status;
      dsel_type   dsel;
      logic       adj_en;
   } cmd_type;

   typedef struct packed {
      logic [3:0] action;
      logic       srch_done;
      logic       srch_hit;
      logic       full;
      logic       clr_done;
      logic       cmp_last;
      logic       cnt_one;
      logic       w_zero;
      logic       nbr_done;
   } stat_type;

   // Matrix word address of row r, column c.
   function automatic logic [MW-1:0] mat_addr(input logic [AW-1:0] r,
                                              input logic [AW-1:0] c);
      return MW'(r) * MW'(MAX_VERTICES) + MW'(c);
   endfunction

endpackage

/* design/amgs_ctrl.sv */
// Command sequencer of the graph store.
`timescale 1ns / 1ps
module amgs_ctrl
   import amgs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [3:0] req_action,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_SRCH_A = 15'b000000000000010,
      S_SRCH_B = 15'b000000000000100,
      S_CLR    = 15'b000000000001000,
      S_ADD    = 15'b000000000010000,
      S_VRD    = 15'b000000000100000,
      S_VOUT   = 15'b000000001000000,
      S_VWR    = 15'b000000010000000,
      S_ERD    = 15'b000000100000000,
      S_EWR    = 15'b000001000000000,
      S_NBR    = 15'b000010000000000,
      S_NEND   = 15'b000100000000000,
      S_CRD    = 15'b001000000000000,
      S_CWR    = 15'b010000000000000,
      S_RMFIN  = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.op     = DP_NOP;
      cmd.emit   = 1'b0;
      cmd.status = ST_OK;
      cmd.dsel   = DS_ZERO;
      cmd.adj_en = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op = DP_LOAD;
               if (req_action <= ACT_SET_EDGE) state_in = S_SRCH_A;
            end
         end
         S_SRCH_A: begin
            cmd.op = DP_SRCH_A;
            if (stat.srch_done) begin
               if (stat.action == ACT_ADD_VERTEX) begin
                  if (stat.srch_hit) begin
                     cmd.emit = 1'b1; cmd.status = ST_PRESENT; state_in = S_IDLE;
                  end else if (stat.full) begin
                     cmd.emit = 1'b1; cmd.status = ST_FULL; state_in = S_IDLE;
                  end else begin
                     state_in = S_CLR;
                  end
               end else if (!stat.srch_hit) begin
                  cmd.emit   = 1'b1;
                  cmd.status = ST_MISSING;
                  cmd.dsel   = (stat.action == ACT_GET_VVAL ||
                                stat.action == ACT_GET_EDGE) ? DS_ONES : DS_ZERO;
                  state_in   = S_IDLE;
               end else if (stat.action == ACT_REM_VERTEX) begin
                  state_in = stat.cnt_one ? S_RMFIN : S_CRD;
               end else if (stat.action == ACT_NEIGHBORS) begin
                  state_in = S_NBR;
               end else if (stat.action == ACT_GET_VVAL) begin
                  state_in = S_VRD;
               end else if (stat.action == ACT_SET_VVAL) begin
                  state_in = S_VWR;
               end else begin
                  state_in = S_SRCH_B;
               end
            end
         end
         S_SRCH_B: begin
            cmd.op = DP_SRCH_B;
            if (stat.srch_done) begin
               if (stat.srch_hit) begin
                  state_in = S_ERD;
               end else begin
                  cmd.emit   = 1'b1;
                  cmd.status = ST_MISSING;
                  cmd.dsel   = (stat.action == ACT_GET_EDGE) ? DS_ONES : DS_ZERO;
                  state_in   = S_IDLE;
               end
            end
         end
         S_CLR: begin
            cmd.op = DP_CLR;
            if (stat.clr_done) state_in = S_ADD;
         end
         S_ADD: begin
            cmd.op = DP_ADD; cmd.emit = 1'b1; state_in = S_IDLE;
         end
         S_VRD: begin
            cmd.op = DP_VRD; state_in = S_VOUT;
         end
         S_VOUT: begin
            cmd.emit = 1'b1; cmd.dsel = DS_VALUE; state_in = S_IDLE;
         end
         S_VWR: begin
            cmd.op = DP_VWR; cmd.emit = 1'b1; state_in = S_IDLE;
         end
         S_ERD: begin
            cmd.op = DP_ERD; state_in = S_EWR;
         end
         S_EWR: begin
            cmd.op     = DP_EWR;
            cmd.emit   = 1'b1;
            cmd.status = ((stat.action == ACT_REM_EDGE || stat.action == ACT_SET_EDGE)
                          && stat.w_zero) ? ST_NO_EDGE : ST_OK;
            cmd.dsel   = (stat.action == ACT_GET_EDGE) ? DS_WEIGHT : DS_ZERO;
            cmd.adj_en = (stat.action == ACT_ADJACENT);
            state_in   = S_IDLE;
         end
         S_NBR: begin
            cmd.op = DP_NBR;
            if (stat.nbr_done) state_in = S_NEND;
         end
         S_NEND: begin
            cmd.op = DP_NEND; state_in = S_IDLE;
         end
         S_CRD: begin
            cmd.op = DP_CRD; state_in = S_CWR;
         end
         S_CWR: begin
            cmd.op   = DP_CWR;
            state_in = stat.cmp_last ? S_RMFIN : S_CRD;
         end
         S_RMFIN: begin
            cmd.op = DP_RMFIN; cmd.emit = 1'b1; state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* design/amgs_dpath.sv */
// Datapath of the graph store: id, value and weight memories, scan counters, result register.
`timescale 1ns / 1ps
module amgs_dpath
   import amgs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_strobe,
   output rsp_type  rsp_data
);

   logic [DW-1:0] id_mem  [MAX_VERTICES];
   logic [DW-1:0] val_mem [MAX_VERTICES];
   logic [DW-1:0] mat_mem [MAT_DEPTH];

   req_type        req_ff;
   logic [CW-1:0]  count_ff;
   logic [CNTW-1:0] cnt_ff;
   logic           vld_ff;
   logic [AW-1:0]  pa_ff, pb_ff;
   logic [AW-1:0]  row_ff, col_ff;
   logic [DW-1:0]  id_rd_ff, val_rd_ff, mat_rd_ff;
   logic           pend_ff;
   logic [DW-1:0]  pend_id_ff, pend_val_ff;
   logic           rsp_strobe_ff;
   rsp_type        rsp_ff;

   logic [CNTW-1:0] cnt_m1;
   logic [CW-1:0]   m_cnt, m_m1;
   logic            searching, hit, scan_end, w_pos, nbr_hit;
   logic [DW-1:0]   key;
   logic [AW-1:0]   src_row, src_col, rd_row;
   logic [MW-1:0]   mat_raddr, mat_waddr;
   logic            mat_we;
   logic [DW-1:0]   mat_wdata;
   logic [CNTW-1:0] cnt_lo;

   assign cnt_m1    = cnt_ff - CNTW'(1);
   assign searching = (cmd.op == DP_SRCH_A) || (cmd.op == DP_SRCH_B);
   assign key       = (cmd.op == DP_SRCH_B) ? req_ff.vertex_b : req_ff.vertex_a;
   assign hit       = vld_ff && (id_rd_ff == key);
   assign scan_end  = !vld_ff && (cnt_ff >= CNTW'(count_ff));
   assign w_pos     = (mat_rd_ff != '0) && !mat_rd_ff[DW-1];
   assign nbr_hit   = vld_ff && w_pos;
   assign m_cnt     = count_ff - CW'(1);
   assign m_m1      = m_cnt - CW'(1);
   assign src_row   = row_ff + AW'(row_ff >= pa_ff);
   assign src_col   = col_ff + AW'(col_ff >= pa_ff);
   assign rd_row    = (cmd.op == DP_CRD) ? src_row : cnt_ff[AW-1:0];
   assign cnt_lo    = cnt_ff - CNTW'(MAX_VERTICES);

   assign stat.action    = req_ff.action;
   assign stat.srch_done = hit || scan_end;
   assign stat.srch_hit  = hit;
   assign stat.full      = (count_ff >= CW'(MAX_VERTICES));
   assign stat.clr_done  = (cnt_ff == CNTW'(2 * MAX_VERTICES - 1));
   assign stat.cmp_last  = (CW'(row_ff) == m_m1) && (CW'(col_ff) == m_m1);
   assign stat.cnt_one   = (count_ff == CW'(1));
   assign stat.w_zero    = (mat_rd_ff == '0);
   assign stat.nbr_done  = scan_end;

   // Matrix address and write selection.
   always_comb begin
      mat_raddr = mat_addr(pb_ff, pa_ff);
      mat_waddr = mat_addr(pb_ff, pa_ff);
      mat_we    = 1'b0;
      mat_wdata = '0;
      case (cmd.op)
         DP_NBR: mat_raddr = mat_addr(cnt_ff[AW-1:0], pa_ff);
         DP_CRD: mat_raddr = mat_addr(src_row, src_col);
         DP_CLR: begin
            mat_we = 1'b1;
            if (cnt_ff < CNTW'(MAX_VERTICES)) begin
               mat_waddr = mat_addr(count_ff[AW-1:0], cnt_ff[AW-1:0]);
            end else begin
               mat_waddr = mat_addr(cnt_lo[AW-1:0], count_ff[AW-1:0]);
            end
         end
         DP_EWR: begin
            case (req_ff.action)
               ACT_ADD_EDGE: begin
                  mat_we = 1'b1; mat_wdata = DW'(1);
               end
               ACT_REM_EDGE: mat_we = (mat_rd_ff != '0);
               ACT_SET_EDGE: begin
                  mat_we = (mat_rd_ff != '0); mat_wdata = req_ff.new_value;
               end
               default: mat_we = 1'b0;
            endcase
         end
         DP_CWR: begin
            mat_we = 1'b1; mat_waddr = mat_addr(row_ff, col_ff); mat_wdata = mat_rd_ff;
         end
         default: mat_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mat_we) mat_mem[mat_waddr] <= mat_wdata;
      mat_rd_ff <= mat_mem[mat_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_ADD) begin
         id_mem[count_ff[AW-1:0]] <= req_ff.vertex_a;
      end else if (cmd.op == DP_CWR && col_ff == '0) begin
         id_mem[row_ff] <= id_rd_ff;
      end
      id_rd_ff <= id_mem[rd_row];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_ADD) begin
         val_mem[count_ff[AW-1:0]] <= '0;
      end else if (cmd.op == DP_VWR) begin
         val_mem[pa_ff] <= req_ff.new_value;
      end else if (cmd.op == DP_CWR && col_ff == '0) begin
         val_mem[row_ff] <= val_rd_ff;
      end
      val_rd_ff <= val_mem[(cmd.op == DP_VRD) ? pa_ff : rd_row];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         case (cmd.op)
            DP_LOAD: begin
               cnt_ff <= '0; vld_ff <= 1'b0; pend_ff <= 1'b0;
               row_ff <= '0; col_ff <= '0;
            end
            DP_SRCH_A, DP_SRCH_B, DP_NBR: begin
               if ((searching && hit) || scan_end) begin
                  cnt_ff <= '0; vld_ff <= 1'b0;
               end else begin
                  cnt_ff <= cnt_ff + CNTW'(1);
                  vld_ff <= (cnt_ff < CNTW'(count_ff));
               end
               if (cmd.op == DP_NBR && nbr_hit) pend_ff <= 1'b1;
            end
            DP_CLR: cnt_ff <= stat.clr_done ? '0 : cnt_ff + CNTW'(1);
            DP_ADD: count_ff <= count_ff + CW'(1);
            DP_RMFIN: count_ff <= count_ff - CW'(1);
            DP_CWR: begin
               if (CW'(col_ff) == m_m1) begin
                  col_ff <= '0; row_ff <= row_ff + AW'(1);
               end else begin
                  col_ff <= col_ff + AW'(1);
               end
            end
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD) req_ff <= req_data;
      if (cmd.op == DP_SRCH_A && hit) pa_ff <= cnt_m1[AW-1:0];
      if (cmd.op == DP_SRCH_B && hit) pb_ff <= cnt_m1[AW-1:0];
      if (cmd.op == DP_NBR && nbr_hit) begin
         pend_id_ff  <= id_rd_ff;
         pend_val_ff <= val_rd_ff;
      end
   end

   // Result register: one transfer per strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit || cmd.op == DP_NEND ||
                          (cmd.op == DP_NBR && nbr_hit && pend_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.status      <= cmd.status;
         rsp_ff.neighbor_id <= '0;
         rsp_ff.is_adjacent <= cmd.adj_en && w_pos;
         rsp_ff.last        <= 1'b1;
         case (cmd.dsel)
            DS_ONES:   rsp_ff.data_word <= '1;
            DS_VALUE:  rsp_ff.data_word <= val_rd_ff;
            DS_WEIGHT: rsp_ff.data_word <= mat_rd_ff;
            default:   rsp_ff.data_word <= '0;
         endcase
      end else if (cmd.op == DP_NEND) begin
         rsp_ff.status      <= pend_ff ? ST_OK : ST_NO_NEIGHBOR;
         rsp_ff.data_word   <= pend_ff ? pend_val_ff : '0;
         rsp_ff.neighbor_id <= pend_ff ? pend_id_ff : '0;
         rsp_ff.is_adjacent <= 1'b0;
         rsp_ff.last        <= 1'b1;
      end else if (cmd.op == DP_NBR && nbr_hit && pend_ff) begin
         rsp_ff.status      <= ST_OK;
         rsp_ff.data_word   <= pend_val_ff;
         rsp_ff.neighbor_id <= pend_id_ff;
         rsp_ff.is_adjacent <= 1'b0;
         rsp_ff.last        <= 1'b0;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* design/adjacency_matrix_graph_store_core.sv */
// Top level of the adjacency matrix graph store.
//
// A command is transferred at a rising edge with start high and busy low;
// req_data carries the action, the two vertex ids and a new value.
// Each result appears on rsp_data for exactly one cycle with rsp_strobe
// high; the receiver cannot stall it. The last result of a command has
// last set. Undefined action codes are dropped and give no result.
// Every command first walks the id table, one entry per cycle; edge
// commands look up both ends. Add vertex then clears its matrix row and
// column. Neighbors walks the matrix column, one vertex per cycle, and
// reports each hit one result later. Remove vertex moves each surviving
// matrix word with a read state (S_CRD) followed by a write state (S_CWR).
// Busy drops in the cycle in which the final result is shown, so the next
// command may follow. Reset empties the graph at once; the memories need
// no clearing pass.
`timescale 1ns / 1ps
module adjacency_matrix_graph_store_core
   import amgs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   amgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_data.action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   amgs_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

/* design/amgs_checker.sv */
// Port-level checks for the graph store, bound to the top level.
`timescale 1ns / 1ps
module amgs_checker
   import amgs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_strobe)
      else $error("block not idle after reset");

   a_bad_action: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.action > ACT_SET_EDGE) |=> !busy && !rsp_strobe)
      else $error("undefined action produced activity");

   a_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.action <= ACT_SET_EDGE) |=> busy)
      else $error("accepted command did not raise busy");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |=> !rsp_strobe)
      else $error("result transfer directly after a final result");

   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> busy)
      else $error("non-final result while idle");

endmodule

bind adjacency_matrix_graph_store_core amgs_checker u_amgs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

/* verif/amgs_checker.sv */
// Checker for the graph store: predicts results from accepted commands and compares them.
`timescale 1ns / 1ps
module amgs_tb_checker
   import amgs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   logic [DW-1:0] g_ids  [MAX_VERTICES];
   logic [DW-1:0] g_vals [MAX_VERTICES];
   logic [DW-1:0] g_wts  [MAX_VERTICES * MAX_VERTICES];
   int            g_count;
   rsp_type       expected_rsps[$];

   assign pending_count = expected_rsps.size();

   function automatic int slot_of(logic [DW-1:0] id);
      for (int i = 0; i < g_count; i++)
         if (g_ids[i] == id) return i;
      return -1;
   endfunction

   function automatic bit is_pos(logic [DW-1:0] w);
      return w != 0 && !w[DW-1];
   endfunction

   function automatic rsp_type mk(logic [2:0] st, logic [DW-1:0] d, logic [DW-1:0] nid,
                                  logic adj, logic lst);
      rsp_type r;
      r.status = st;
      r.data_word = d;
      r.neighbor_id = nid;
      r.is_adjacent = adj;
      r.last = lst;
      return r;
   endfunction

   task automatic drop_slot(int p);
      int a, b;
      a = 0;
      for (int i = 0; i < g_count; i++) begin
         if (i == p) continue;
         b = 0;
         for (int j = 0; j < g_count; j++) begin
            if (j == p) continue;
            g_wts[a * MAX_VERTICES + b] = g_wts[i * MAX_VERTICES + j];
            b++;
         end
         g_ids[a] = g_ids[i];
         g_vals[a] = g_vals[i];
         a++;
      end
      g_count--;
   endtask

   task automatic apply_command(req_type q);
      int pa, pb, widx, k;
      pa = slot_of(q.vertex_a);
      if (q.action > ACT_SET_EDGE) return;
      if (q.action == ACT_ADD_VERTEX) begin
         if (pa >= 0) expected_rsps.push_back(mk(ST_PRESENT, 0, 0, 0, 1));
         else if (g_count >= MAX_VERTICES) expected_rsps.push_back(mk(ST_FULL, 0, 0, 0, 1));
         else begin
            g_ids[g_count] = q.vertex_a;
            g_vals[g_count] = 0;
            for (int i = 0; i < MAX_VERTICES; i++) begin
               g_wts[g_count * MAX_VERTICES + i] = 0;
               g_wts[i * MAX_VERTICES + g_count] = 0;
            end
            g_count++;
            expected_rsps.push_back(mk(ST_OK, 0, 0, 0, 1));
         end
         return;
      end
      if (pa < 0) begin
         expected_rsps.push_back(mk(ST_MISSING,
            (q.action == ACT_GET_VVAL || q.action == ACT_GET_EDGE) ? '1 : '0, 0, 0, 1));
         return;
      end
      case (q.action)
         ACT_REM_VERTEX: begin
            drop_slot(pa);
            expected_rsps.push_back(mk(ST_OK, 0, 0, 0, 1));
            return;
         end
         ACT_NEIGHBORS: begin
            k = 0;
            for (int i = 0; i < g_count; i++)
               if (is_pos(g_wts[i * MAX_VERTICES + pa])) begin
                  expected_rsps.push_back(mk(ST_OK, g_vals[i], g_ids[i], 0, 0));
                  k++;
               end
            if (k == 0) expected_rsps.push_back(mk(ST_NO_NEIGHBOR, 0, 0, 0, 1));
            else expected_rsps[$].last = 1'b1;
            return;
         end
         ACT_GET_VVAL: begin
            expected_rsps.push_back(mk(ST_OK, g_vals[pa], 0, 0, 1));
            return;
         end
         ACT_SET_VVAL: begin
            g_vals[pa] = q.new_value;
            expected_rsps.push_back(mk(ST_OK, 0, 0, 0, 1));
            return;
         end
         default: ;
      endcase
      pb = slot_of(q.vertex_b);
      if (pb < 0) begin
         expected_rsps.push_back(mk(ST_MISSING, q.action == ACT_GET_EDGE ? '1 : '0, 0, 0, 1));
         return;
      end
      widx = pb * MAX_VERTICES + pa;
      case (q.action)
         ACT_ADD_EDGE: begin
            g_wts[widx] = 1;
            expected_rsps.push_back(mk(ST_OK, 0, 0, 0, 1));
         end
         ACT_REM_EDGE, ACT_SET_EDGE: begin
            if (g_wts[widx] == 0) expected_rsps.push_back(mk(ST_NO_EDGE, 0, 0, 0, 1));
            else begin
               g_wts[widx] = (q.action == ACT_REM_EDGE) ? '0 : q.new_value;
               expected_rsps.push_back(mk(ST_OK, 0, 0, 0, 1));
            end
         end
         ACT_ADJACENT: expected_rsps.push_back(mk(ST_OK, 0, 0, is_pos(g_wts[widx]), 1));
         default: expected_rsps.push_back(mk(ST_OK, g_wts[widx], 0, 0, 1));
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         g_count = 0;
         fail_count = 0;
         expected_rsps.delete();
      end else begin
         // A result shown in the same cycle as a new transfer belongs to the older command.
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p, actual %p", want, rsp_data);
               end
            end
         end
         if (start && !busy) apply_command(req_data);
      end
   end

endmodule

/* verif/tb_top.sv */
// Testbench top for the graph store: drives commands and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
   import amgs_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count, pending_count;
   int      cycle_count = 0;
   int      idle_pct = 0;
   logic [DW-1:0] id_pool [8];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   adjacency_matrix_graph_store_core i_dut (.*);

   amgs_tb_checker i_chk (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 1000000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Start stays high after the transfer so that back-to-back commands need no gap.
   task automatic send(logic [3:0] act, logic [DW-1:0] a, logic [DW-1:0] b, logic [DW-1:0] v);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= '{act, a, b, v};
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic logic [DW-1:0] pick_id();
      return ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(7)];
   endfunction

   initial begin
      id_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0, 32'h1,
                  32'h5a5a_a5a5, 32'ha5a5_5a5a, 32'h1234_5678};
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // Directed part: empty-graph misses, extremes, full table, duplicates, edges.
      send(ACT_GET_VVAL, 32'h0, 0, 0);
      send(ACT_GET_EDGE, 32'h1, 32'h1, 0);
      for (int i = 0; i < MAX_VERTICES; i++) send(ACT_ADD_VERTEX, 32'h8000_0000 + i, 0, 0);
      send(ACT_ADD_VERTEX, 32'h7fff_ffff, 0, 0);
      send(ACT_ADD_VERTEX, 32'h8000_0000, 0, 0);
      send(ACT_SET_VVAL, 32'h8000_0003, 0, 32'hffff_ffff);
      send(ACT_ADD_EDGE, 32'h8000_0000, 32'h8000_0003, 0);
      send(ACT_NEIGHBORS, 32'h8000_0000, 0, 0);
      send(ACT_SET_EDGE, 32'h8000_0000, 32'h8000_0003, 32'h8000_0000);
      send(ACT_ADJACENT, 32'h8000_0000, 32'h8000_0003, 0);
      send(ACT_NEIGHBORS, 32'h8000_0000, 0, 0);
      send(ACT_REM_VERTEX, 32'h8000_0001, 0, 0);
      send(ACT_GET_EDGE, 32'h8000_0000, 32'h8000_0003, 0);
      send(ACT_SET_EDGE, 32'h8000_0000, 32'h8000_0003, 32'h0);
      send(ACT_REM_EDGE, 32'h8000_0000, 32'h8000_0003, 0);
      // Pause until the block has delivered everything.
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      send(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      for (int i = 0; i < 15; i++) send(ACT_REM_VERTEX, 32'h8000_0000 + i, 0, 0);
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 83 : (ph == 3) ? 18 : 0;
         for (int n = 0; n < 46; n++) begin
            int r;
            logic [3:0] act;
            r = $urandom_range(99);
            act = (r < 22) ? ACT_ADD_VERTEX : (r < 30) ? ACT_REM_VERTEX :
                  (r < 50) ? ACT_ADD_EDGE : (r < 97) ? 4'($urandom_range(9)) :
                  4'($urandom_range(15, 10));
            send(act, pick_id(), pick_id(), $urandom);
         end
      end
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (600) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

/* sim.f */
design/amgs_pkg.sv
design/amgs_ctrl.sv
design/amgs_dpath.sv
design/adjacency_matrix_graph_store_core.sv
design/amgs_checker.sv
verif/amgs_checker.sv
verif/tb_top.sv
